// ===== rtl/mclb_pkg.sv =====
// Shared constants, types and helpers for the multi-channel lamp blinker.
package mclb_pkg;

    localparam int NUM_CHANNELS  = 32;
    localparam int INTERVAL_BITS = 16;
    localparam int LEVEL_BITS    = 32;
    localparam int LIVE_CHANNELS = (NUM_CHANNELS < LEVEL_BITS) ? NUM_CHANNELS : LEVEL_BITS;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_FLASH = 2'd2;

    typedef logic [INTERVAL_BITS-1:0] t_ivl;

    typedef struct packed {
        logic [1:0] mode;
        t_ivl       interval;
    } t_set_cmd;

    // Zero-extend or truncate the 16-bit request interval to the stored width.
    function automatic t_ivl fit_interval(input logic [15:0] v);
        logic [31:0] w;
        w = {16'b0, v};
        return w[INTERVAL_BITS-1:0];
    endfunction

endpackage

// ===== rtl/mclb_cell.sv =====
// One lamp channel cell: mode, interval, countdown, phase and level, with tick pass-through.
module mclb_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_set_en,
    input  mclb_pkg::t_set_cmd i_set,
    input  logic               i_present,
    input  logic               i_tick,
    output logic               o_tick,
    output logic               o_level
);

    logic [1:0]     r_mode,  n_mode;
    mclb_pkg::t_ivl r_ivl,   n_ivl;
    mclb_pkg::t_ivl r_cnt,   n_cnt;
    logic           r_phase, n_phase;
    logic           r_level, n_level;
    logic           r_tick;
    mclb_pkg::t_ivl w_dec;

    assign w_dec = r_cnt - mclb_pkg::t_ivl'(1);

    always_comb begin
        n_mode  = r_mode;
        n_ivl   = r_ivl;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_level = r_level;
        if (i_set_en && (i_set.mode != r_mode)) begin
            // mode change: drop phase and any flashing first
            n_mode  = i_set.mode;
            n_ivl   = '0;
            n_cnt   = '0;
            n_phase = 1'b0;
            case (i_set.mode)
                mclb_pkg::MODE_OFF: begin
                    n_level = 1'b0;
                end
                mclb_pkg::MODE_ON: begin
                    n_level = 1'b1;
                end
                mclb_pkg::MODE_FLASH: begin
                    n_ivl = i_set.interval;
                    n_cnt = i_set.interval;
                end
                default: begin
                end
            endcase
        end else if (i_tick && i_present && (r_ivl != '0)) begin
            if (w_dec == '0) begin
                n_level = r_phase;
                n_cnt   = r_ivl;
                n_phase = ~r_phase;
            end else begin
                n_cnt = w_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= mclb_pkg::MODE_OFF;
            r_ivl   <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
            r_level <= 1'b0;
            r_tick  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_ivl   <= n_ivl;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_level <= n_level;
            r_tick  <= i_tick;
        end
    end

    assign o_tick  = r_tick;
    assign o_level = r_level;

endmodule

// ===== rtl/multi_channel_led_blinker_core.sv =====
// Top level: request control, channel-present register, cell chain and result register.
// Set request: the item goes to the done state, and the result register loads once the output is free.
// Tick: a token walks the cell chain one channel per cycle; after it leaves the last channel
//   the block goes to the done state and the result register loads once the output is free.
// The next item is taken once the current one is finished, even while its result waits.
// Reset (synchronous, active low): all channels off, levels and phases zero, all present.
module multi_channel_led_blinker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [4:0]  i_channel,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_interval,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_lamp_levels,
    output logic        o_status
);

    localparam int LIVE = mclb_pkg::LIVE_CHANNELS;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state             r_state;
    logic [31:0]        r_present;
    logic               r_stat_pend;
    logic [31:0]        r_levels;
    logic               r_status;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_ok;
    logic               w_set_go;
    logic [LIVE-1:0]    w_set_en;
    logic [LIVE:0]      w_tok;
    logic [LIVE-1:0]    w_level;
    logic [31:0]        w_levels;
    logic               w_load;
    mclb_pkg::t_set_cmd w_cmd;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ok       = ({1'b0, i_channel} < 6'(LIVE)) && r_present[i_channel];
    assign w_set_go   = w_accept && !i_req_type && w_ok;
    assign w_tok[0]   = w_accept && i_req_type;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_cmd.mode     = i_mode;
    assign w_cmd.interval = mclb_pkg::fit_interval(i_interval);

    always_comb begin
        w_levels = '0;
        for (int k = 0; k < LIVE; k++) begin
            w_levels[k] = w_level[k];
        end
    end

    for (genvar k = 0; k < LIVE; k++) begin : g_cell
        assign w_set_en[k] = w_set_go && (i_channel == 5'(k));
        mclb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_set_en  (w_set_en[k]),
            .i_set     (w_cmd),
            .i_present (r_present[k]),
            .i_tick    (w_tok[k]),
            .o_tick    (w_tok[k+1]),
            .o_level   (w_level[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '1;
            r_stat_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_levels    <= '0;
            r_status    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_present <= i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_stat_pend <= !i_req_type && !w_ok;
                        r_state     <= i_req_type ? S_RUN : S_DONE;
                    end
                end
                S_RUN: begin
                    // wait for the token to leave the last channel
                    if (w_tok[LIVE]) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_levels    <= w_levels;
                        r_status    <= r_stat_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lamp_levels = r_levels;
    assign o_status      = r_status;

`ifndef ASSERT_OFF
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok[LIVE:1]))
        else $error("more than one tick token in the cell chain");

    a_token_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok[LIVE:1] != '0) |-> (r_state == S_RUN))
        else $error("tick token walking outside the run state");

    a_tick_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type) |=> (r_state == S_RUN))
        else $error("accepted tick did not start a chain walk");

    a_set_has_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_set_en != '0) |-> (w_tok == '0))
        else $error("set request overlaps a tick walk");
`endif

endmodule

// ===== tb/multi_channel_led_blinker_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-channel lamp blinker core.
module multi_channel_led_blinker_core_tb;

    localparam logic       REQ_SET       = 1'b0;
    localparam logic       REQ_TICK      = 1'b1;
    localparam logic [1:0] MODE_OTHER    = 2'd3;
    localparam logic       ST_OK         = 1'b0;
    localparam logic       ST_ABSENT     = 1'b1;
    localparam int         RAND_ITEMS    = 950;
    localparam int         MASK_PHASES   = 7;
    localparam int         SETTLE_CYCLES = mclb_pkg::NUM_CHANNELS + 8;
    localparam int         MAX_REPORTS   = 25;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  channel;
        logic [1:0]  mode;
        logic [15:0] interval;
    } t_lamp_req;

    typedef struct packed {
        logic [31:0] levels;
        logic        status;
    } t_lamp_result;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_req_type  = 1'b0;
    logic [4:0]  i_channel   = '0;
    logic [1:0]  i_mode      = '0;
    logic [15:0] i_interval  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_lamp_levels;
    logic        o_status;

    multi_channel_led_blinker_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_channel     (i_channel),
        .i_mode        (i_mode),
        .i_interval    (i_interval),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_lamp_levels (o_lamp_levels),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected channel state
    logic [31:0]    present_mask;
    logic [1:0]     chan_mode_q [mclb_pkg::NUM_CHANNELS];
    mclb_pkg::t_ivl chan_ivl_q  [mclb_pkg::NUM_CHANNELS];
    mclb_pkg::t_ivl chan_cnt_q  [mclb_pkg::NUM_CHANNELS];
    logic [31:0]    phase_q;
    logic [31:0]    level_q;

    t_lamp_req    req_backlog[$];
    t_lamp_result levels_due[$];
    t_lamp_req    offered;
    bit           offer_busy;
    int unsigned  send_gap, send_calm, hold_left, recv_calm;
    int unsigned  err_count, n_items, n_ticks, n_rejects, n_results, n_masks;

    function automatic t_lamp_result lamp_update(input t_lamp_req r);
        t_lamp_result res;
        res.status = ST_OK;
        if (r.req_type == REQ_SET) begin
            if (r.channel >= mclb_pkg::LIVE_CHANNELS || !present_mask[r.channel]) begin
                res.status = ST_ABSENT;
            end else if (chan_mode_q[r.channel] != r.mode) begin
                phase_q[r.channel]     = 1'b0;
                chan_mode_q[r.channel] = r.mode;
                chan_ivl_q[r.channel]  = '0;
                chan_cnt_q[r.channel]  = '0;
                case (r.mode)
                    mclb_pkg::MODE_OFF: level_q[r.channel] = 1'b0;
                    mclb_pkg::MODE_ON:  level_q[r.channel] = 1'b1;
                    mclb_pkg::MODE_FLASH: begin
                        chan_ivl_q[r.channel] = mclb_pkg::t_ivl'(r.interval);
                        chan_cnt_q[r.channel] = mclb_pkg::t_ivl'(r.interval);
                    end
                    default: ;
                endcase
            end
        end else begin
            for (int k = 0; k < mclb_pkg::LIVE_CHANNELS; k++) begin
                if (present_mask[k] && chan_ivl_q[k] != '0) begin
                    chan_cnt_q[k] = chan_cnt_q[k] - 1'b1;
                    if (chan_cnt_q[k] == '0) begin
                        level_q[k]    = phase_q[k];
                        chan_cnt_q[k] = chan_ivl_q[k];
                        phase_q[k]    = ~phase_q[k];
                    end
                end
            end
        end
        res.levels = level_q;
        return res;
    endfunction

    function automatic t_lamp_req mk_req(input logic kind, input logic [4:0] ch,
                                         input logic [1:0] md, input logic [15:0] ivl);
        t_lamp_req r;
        r.req_type = kind;
        r.channel  = ch;
        r.mode     = md;
        r.interval = ivl;
        return r;
    endfunction

    // Sets favour channels 0-7 and short intervals, so ticks toggle lamps often.
    function automatic t_lamp_req random_req();
        t_lamp_req   r;
        int unsigned pick;
        r = t_lamp_req'(24'($urandom));
        if ($urandom_range(0, 99) < 40) begin
            r.req_type = REQ_TICK;
            return r;
        end
        r.req_type = REQ_SET;
        if ($urandom_range(0, 1) == 0)
            r.channel = 5'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 2)      r.mode = mclb_pkg::MODE_OFF;
        else if (pick < 4) r.mode = mclb_pkg::MODE_ON;
        else if (pick < 6) r.mode = MODE_OTHER;
        else               r.mode = mclb_pkg::MODE_FLASH;
        pick = $urandom_range(0, 19);
        if (pick == 0)       r.interval = '0;
        else if (pick < 15)  r.interval = 16'($urandom_range(1, 4));
        else if (pick < 18)  r.interval = 16'($urandom_range(5, 40));
        else                 r.interval = 16'($urandom);
        return r;
    endfunction

    // Random wait per item, with occasional stretches of back-to-back traffic.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                levels_due.push_back(lamp_update(offered));
                n_items++;
                if (offered.req_type == REQ_TICK)
                    n_ticks++;
                else if (levels_due[$].status == ST_ABSENT)
                    n_rejects++;
                offer_busy = 1'b0;
                send_gap   = draw_wait(send_calm);
            end
            if (!offer_busy) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (req_backlog.size() != 0) begin
                    offered    = req_backlog.pop_front();
                    offer_busy = 1'b1;
                    i_req_type <= offered.req_type;
                    i_channel  <= offered.channel;
                    i_mode     <= offered.mode;
                    i_interval <= offered.interval;
                end
            end
            i_in_valid <= offer_busy;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (levels_due.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got levels %h status %b",
                                 $time, o_lamp_levels, o_status);
                end else begin
                    t_lamp_result want;
                    want = levels_due.pop_front();
                    if (o_lamp_levels !== want.levels)
                        flag_mismatch("lamp_levels", want.levels, o_lamp_levels);
                    if (o_status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(o_status));
                end
                hold_left = draw_wait(recv_calm);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_present(input logic [31:0] mask);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        present_mask = mask;
        n_masks++;
    endtask

    // Hold until every queued item is through and its result checked.
    task automatic settle();
        while (req_backlog.size() != 0 || offer_busy || levels_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] mask_plan [MASK_PHASES];
        present_mask = '1;
        phase_q      = '0;
        level_q      = '0;
        for (int c = 0; c < mclb_pkg::NUM_CHANNELS; c++) begin
            chan_mode_q[c] = mclb_pkg::MODE_OFF;
            chan_ivl_q[c]  = '0;
            chan_cnt_q[c]  = '0;
        end
        mask_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, $urandom,
                      32'h8000_0001, $urandom, 32'hFFFF_FFFF};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_present(32'hFFFF_FFFF);

        // Directed: on/off at both ends, same-mode set, flash with short, zero and
        // full-range intervals, ticks with extreme ignored fields, other mode.
        req_backlog.push_back(mk_req(REQ_SET,  5'd0,  mclb_pkg::MODE_ON,    16'h0000));
        req_backlog.push_back(mk_req(REQ_SET,  5'd31, mclb_pkg::MODE_ON,    16'hFFFF));
        req_backlog.push_back(mk_req(REQ_SET,  5'd0,  mclb_pkg::MODE_ON,    16'h1234));
        req_backlog.push_back(mk_req(REQ_SET,  5'd31, mclb_pkg::MODE_OFF,   16'h0000));
        req_backlog.push_back(mk_req(REQ_SET,  5'd1,  mclb_pkg::MODE_FLASH, 16'h0001));
        req_backlog.push_back(mk_req(REQ_SET,  5'd2,  mclb_pkg::MODE_FLASH, 16'h0002));
        req_backlog.push_back(mk_req(REQ_SET,  5'd3,  mclb_pkg::MODE_FLASH, 16'h0000));
        req_backlog.push_back(mk_req(REQ_SET,  5'd30, mclb_pkg::MODE_FLASH, 16'hFFFF));
        req_backlog.push_back(mk_req(REQ_TICK, 5'd31, MODE_OTHER,           16'hFFFF));
        req_backlog.push_back(mk_req(REQ_TICK, 5'd0,  mclb_pkg::MODE_OFF,   16'h0000));
        req_backlog.push_back(mk_req(REQ_TICK, 5'd15, mclb_pkg::MODE_FLASH, 16'h8001));
        req_backlog.push_back(mk_req(REQ_SET,  5'd0,  MODE_OTHER,           16'h0000));
        req_backlog.push_back(mk_req(REQ_SET,  5'd1,  MODE_OTHER,           16'h0005));
        req_backlog.push_back(mk_req(REQ_TICK, 5'd1,  mclb_pkg::MODE_ON,    16'h0000));
        settle();

        // Drop channels 0 and 31: sets there are rejected, ticks skip them.
        write_present(32'h7FFF_FFFE);
        req_backlog.push_back(mk_req(REQ_SET,  5'd0,  mclb_pkg::MODE_OFF,   16'h0000));
        req_backlog.push_back(mk_req(REQ_SET,  5'd31, mclb_pkg::MODE_FLASH, 16'h0001));
        req_backlog.push_back(mk_req(REQ_TICK, 5'd0,  mclb_pkg::MODE_OFF,   16'h0000));
        req_backlog.push_back(mk_req(REQ_TICK, 5'd31, MODE_OTHER,           16'hFFFF));
        req_backlog.push_back(mk_req(REQ_SET,  5'd2,  mclb_pkg::MODE_OFF,   16'h0000));

        for (int p = 0; p < MASK_PHASES; p++) begin
            settle();
            write_present(mask_plan[p]);
            repeat (RAND_ITEMS / MASK_PHASES) req_backlog.push_back(random_req());
        end
        settle();

        $display("Ran %0d items (%0d ticks, %0d sets to absent channels), %0d results checked,",
                 n_items, n_ticks, n_rejects, n_results);
        $display("across %0d channel-present settings including none and all present.", n_masks);
        if (err_count == 0 && levels_due.size() == 0) begin
            $display("multi_channel_led_blinker_core test passed");
        end else begin
            $display("multi_channel_led_blinker_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", levels_due.size());
        $display("multi_channel_led_blinker_core test failed");
        $finish;
    end

endmodule

// ===== multi_channel_led_blinker_core.f =====
rtl/mclb_pkg.sv
rtl/mclb_cell.sv
rtl/multi_channel_led_blinker_core.sv
tb/multi_channel_led_blinker_core_tb.sv
